>>> rtl/rgbhsv_pkg.sv
package rgbhsv_pkg;

    localparam int CH_BITS       = 8;
    localparam int HUE_FRAC_BITS = 6;

    // hue spans 0 .. 360 degrees, so nine integer bits
    localparam int HUE_BITS  = 9 + HUE_FRAC_BITS;
    // sixty degrees times a ratio of at most one stays below 64 degrees
    localparam int HUEQ_BITS = 6 + HUE_FRAC_BITS;

    localparam logic [CH_BITS-1:0]   CH_MAX    = '1;
    localparam logic [HUEQ_BITS-1:0] HUE_SCALE = HUEQ_BITS'(60 << HUE_FRAC_BITS);
    localparam logic [HUE_BITS-1:0]  HUE_FULL  = HUE_BITS'(360 << HUE_FRAC_BITS);
    localparam logic [HUE_BITS-1:0]  HUE_GREEN = HUE_BITS'(120 << HUE_FRAC_BITS);
    localparam logic [HUE_BITS-1:0]  HUE_BLUE  = HUE_BITS'(240 << HUE_FRAC_BITS);

    // quotient bits are spread over this many divider stages
    localparam int DIV_STAGES = 3;
    localparam int SAT_PER    = (CH_BITS + DIV_STAGES - 1) / DIV_STAGES;
    localparam int HUE_PER    = (HUEQ_BITS + DIV_STAGES - 1) / DIV_STAGES;

    localparam logic [1:0] SECTOR_RED   = 2'd0;
    localparam logic [1:0] SECTOR_GREEN = 2'd1;
    localparam logic [1:0] SECTOR_BLUE  = 2'd2;

    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [HUE_BITS-1:0] hue;
        logic [CH_BITS-1:0]  saturation;
        logic [CH_BITS-1:0]  value;
    } hsv_t;

    typedef struct packed {
        logic [CH_BITS-1:0]   value;
        logic                 gray;
        logic [1:0]           sector;
        logic                 diff_neg;
        logic [CH_BITS-1:0]   delta;
        logic [CH_BITS-1:0]   sat_rem;
        logic [CH_BITS-1:0]   sat_dvd;
        logic [CH_BITS-1:0]   sat_q;
        logic [CH_BITS-1:0]   hue_rem;
        logic [HUEQ_BITS-1:0] hue_dvd;
        logic [HUEQ_BITS-1:0] hue_q;
    } work_t;

endpackage

>>> rtl/rgbhsv_prep.sv
module rgbhsv_prep (
    input  logic                clk,
    input  logic                en,
    input  rgbhsv_pkg::rgb_t    pixel,
    output rgbhsv_pkg::work_t   work
);
    import rgbhsv_pkg::*;

    localparam int SAT_W = 2 * CH_BITS;
    localparam int HUE_W = CH_BITS + HUEQ_BITS;

    work_t work_reg;
    work_t work_next;

    always_comb
    begin
        logic [CH_BITS-1:0] mx;
        logic [CH_BITS-1:0] mn;
        logic [CH_BITS-1:0] dlt;
        logic [CH_BITS-1:0] a;
        logic [CH_BITS-1:0] b;
        logic [CH_BITS-1:0] mag;
        logic [SAT_W-1:0]   sat_prod;
        logic [HUE_W-1:0]   hue_prod;

        mx = (pixel.red > pixel.green) ? pixel.red : pixel.green;
        mx = (mx > pixel.blue) ? mx : pixel.blue;
        mn = (pixel.red < pixel.green) ? pixel.red : pixel.green;
        mn = (mn < pixel.blue) ? mn : pixel.blue;
        dlt = mx - mn;

        // ties go to red, then green
        if (pixel.red >= mx)
        begin
            work_next.sector = SECTOR_RED;
            a = pixel.green;
            b = pixel.blue;
        end
        else if (pixel.green >= mx)
        begin
            work_next.sector = SECTOR_GREEN;
            a = pixel.blue;
            b = pixel.red;
        end
        else
        begin
            work_next.sector = SECTOR_BLUE;
            a = pixel.red;
            b = pixel.green;
        end

        work_next.diff_neg = (a < b);
        mag = (a < b) ? (b - a) : (a - b);

        // dividends: cmax*delta over max, and scaled |diff| over delta
        sat_prod = SAT_W'(dlt) * SAT_W'(CH_MAX);
        hue_prod = HUE_W'(mag) * HUE_W'(HUE_SCALE);

        work_next.value   = mx;
        work_next.gray    = (dlt == '0);
        work_next.delta   = dlt;
        work_next.sat_rem = sat_prod[SAT_W-1:CH_BITS];
        work_next.sat_dvd = sat_prod[CH_BITS-1:0];
        work_next.sat_q   = '0;
        work_next.hue_rem = hue_prod[HUE_W-1:HUEQ_BITS];
        work_next.hue_dvd = hue_prod[HUEQ_BITS-1:0];
        work_next.hue_q   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
        end
    end

    assign work = work_reg;

endmodule

>>> rtl/rgbhsv_div_stage.sv
module rgbhsv_div_stage #(
    parameter int STAGE = 0
) (
    input  logic                clk,
    input  logic                en,
    input  rgbhsv_pkg::work_t   work_in,
    output rgbhsv_pkg::work_t   work_out
);
    import rgbhsv_pkg::*;

    localparam int SAT_LEFT = CH_BITS - STAGE * SAT_PER;
    localparam int HUE_LEFT = HUEQ_BITS - STAGE * HUE_PER;
    localparam int SAT_N = (SAT_LEFT > SAT_PER) ? SAT_PER : ((SAT_LEFT > 0) ? SAT_LEFT : 0);
    localparam int HUE_N = (HUE_LEFT > HUE_PER) ? HUE_PER : ((HUE_LEFT > 0) ? HUE_LEFT : 0);

    work_t work_reg;
    work_t work_next;

    // restoring division, remainder always below a nonzero divisor
    always_comb
    begin
        logic [CH_BITS:0] trial;
        logic             qbit;

        work_next = work_in;

        for (int i = 0; i < SAT_N; i++)
        begin
            trial = {work_next.sat_rem, work_next.sat_dvd[CH_BITS-1]};
            work_next.sat_dvd = work_next.sat_dvd << 1;
            qbit = (trial >= {1'b0, work_next.value});
            if (qbit)
            begin
                trial = trial - {1'b0, work_next.value};
            end
            work_next.sat_rem = trial[CH_BITS-1:0];
            work_next.sat_q = {work_next.sat_q[CH_BITS-2:0], qbit};
        end

        for (int i = 0; i < HUE_N; i++)
        begin
            trial = {work_next.hue_rem, work_next.hue_dvd[HUEQ_BITS-1]};
            work_next.hue_dvd = work_next.hue_dvd << 1;
            qbit = (trial >= {1'b0, work_next.delta});
            if (qbit)
            begin
                trial = trial - {1'b0, work_next.delta};
            end
            work_next.hue_rem = trial[CH_BITS-1:0];
            work_next.hue_q = {work_next.hue_q[HUEQ_BITS-2:0], qbit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
        end
    end

    assign work_out = work_reg;

endmodule

>>> rtl/rgbhsv_finish.sv
module rgbhsv_finish (
    input  logic                clk,
    input  logic                en,
    input  rgbhsv_pkg::work_t   work,
    output rgbhsv_pkg::hsv_t    hsv
);
    import rgbhsv_pkg::*;

    hsv_t hsv_reg;
    hsv_t hsv_next;

    always_comb
    begin
        logic [HUE_BITS-1:0] q_ext;
        logic [HUE_BITS-1:0] rem_nz;
        logic [HUE_BITS-1:0] hue_val;

        q_ext  = HUE_BITS'(work.hue_q);
        rem_nz = HUE_BITS'(work.hue_rem != '0);

        // negative difference off a nonzero sector floors, so round the magnitude up
        unique case (work.sector)
            SECTOR_RED:
            begin
                if (work.diff_neg && (q_ext != '0))
                begin
                    hue_val = HUE_FULL - q_ext;
                end
                else if (work.diff_neg)
                begin
                    hue_val = '0;
                end
                else
                begin
                    hue_val = q_ext;
                end
            end
            SECTOR_GREEN:
            begin
                hue_val = work.diff_neg ? (HUE_GREEN - q_ext - rem_nz) : (HUE_GREEN + q_ext);
            end
            SECTOR_BLUE:
            begin
                hue_val = work.diff_neg ? (HUE_BLUE - q_ext - rem_nz) : (HUE_BLUE + q_ext);
            end
            default:
            begin
                hue_val = '0;
            end
        endcase

        hsv_next.hue        = work.gray ? '0 : hue_val;
        hsv_next.saturation = work.gray ? '0 : work.sat_q;
        hsv_next.value      = work.value;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hsv_reg <= hsv_next;
        end
    end

    assign hsv = hsv_reg;

endmodule

>>> rtl/rgb_to_hsv_converter_top.sv
// channel   direction   handshake                  payload
// pixel     in          pixel_valid / pixel_stall  rgb_t: red, green, blue
// hsv       out         hsv_valid / hsv_stall      hsv_t: hue, saturation, value
//
// five register stages: min/max and dividend setup, three divider stages,
// hue assembly; one pixel enters every cycle while pixel_stall is low
// the divider stages set the depth, each resolves up to three saturation and four hue quotient bits
// reset clears only the stage valid bits, the pipeline comes up empty
// a stalled stage holds, upstream stages keep filling any empty stage
module rgb_to_hsv_converter_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_stall,
    input  rgbhsv_pkg::rgb_t    pixel,
    output logic                hsv_valid,
    input  logic                hsv_stall,
    output rgbhsv_pkg::hsv_t    hsv
);
    import rgbhsv_pkg::*;

    localparam int NST = DIV_STAGES + 2;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] ready;
    logic [NST-1:0] up_valid;
    logic [NST-1:0] load;

    work_t work_pipe [DIV_STAGES+1];

    always_comb
    begin
        ready[NST-1] = !valid_reg[NST-1] || !hsv_stall;
        for (int k = NST - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign up_valid = {valid_reg[NST-2:0], pixel_valid};
    assign load     = ready & up_valid;

    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            valid_next[k] = ready[k] ? up_valid[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    rgbhsv_prep u_prep (
        .clk   (clk),
        .en    (load[0]),
        .pixel (pixel),
        .work  (work_pipe[0])
    );

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        rgbhsv_div_stage #(
            .STAGE (s)
        ) u_div (
            .clk      (clk),
            .en       (load[s+1]),
            .work_in  (work_pipe[s]),
            .work_out (work_pipe[s+1])
        );
    end

    rgbhsv_finish u_finish (
        .clk  (clk),
        .en   (load[NST-1]),
        .work (work_pipe[DIV_STAGES]),
        .hsv  (hsv)
    );

    assign pixel_stall = !ready[0];
    assign hsv_valid   = valid_reg[NST-1];

    // a transfer in always lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall |=> valid_reg[0])
        else $error("accepted pixel did not enter the pipeline");

    // hue stays below a full turn
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (hsv.hue < HUE_FULL))
        else $error("hue out of range");

    // zero saturation only for gray, which has zero hue
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && (hsv.saturation == '0) |-> (hsv.hue == '0))
        else $error("gray pixel with nonzero hue");

    // saturation never exceeds zero when value is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && (hsv.value == '0) |-> (hsv.saturation == '0))
        else $error("black pixel with nonzero saturation");

endmodule

>>> tb/tb_rgb_to_hsv_converter_top.sv
module tb_rgb_to_hsv_converter_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rgbhsv_pkg::*;

    localparam int RANDOM_PIXELS = 850;
    localparam int CALM_FIRST    = 300;
    localparam int CALM_LAST     = 500;
    localparam int DRAIN_AT      = 620;
    localparam int IDLE_PCT      = 17;

    typedef struct {
        rgb_t px;
        bit   known;
        hsv_t want;
    } pixel_row_t;

    logic clk         = 1'b0;
    logic rst_n       = 1'b0;
    logic pixel_valid = 1'b0;
    rgb_t pixel       = '0;
    logic hsv_stall   = 1'b0;
    logic pixel_stall;
    logic hsv_valid;
    hsv_t hsv;

    // no idling on either side while this is set
    bit calm = 1'b0;

    hsv_t       hsv_pending[$];
    pixel_row_t pixel_plan[$];
    int         errors = 0;

    rgb_to_hsv_converter_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .hsv_valid   (hsv_valid),
        .hsv_stall   (hsv_stall),
        .hsv         (hsv)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic hsv_t hsv_of(rgb_t px);
        int   r;
        int   g;
        int   b;
        int   mx;
        int   mn;
        int   delta;
        int   diff;
        int   offset;
        int   num;
        int   angle;
        hsv_t res;
        r  = px.red;
        g  = px.green;
        b  = px.blue;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        delta = mx - mn;
        res.value = CH_BITS'(mx);
        if (delta == 0)
        begin
            res.hue        = '0;
            res.saturation = '0;
            return res;
        end
        res.saturation = CH_BITS'((int'(CH_MAX) * delta) / mx);
        // ties resolve red first, then green
        if (r >= mx)
        begin
            diff   = g - b;
            offset = 0;
        end
        else if (g >= mx)
        begin
            diff   = b - r;
            offset = int'(HUE_GREEN);
        end
        else
        begin
            diff   = r - g;
            offset = int'(HUE_BLUE);
        end
        num = offset * delta + int'(HUE_SCALE) * diff;
        // signed division truncates toward zero
        angle = num / delta;
        if (angle < 0)
            angle += int'(HUE_FULL);
        res.hue = HUE_BITS'(angle);
        return res;
    endfunction

    task automatic add_row(int r, int g, int b, bit known, int h, int s, int v);
        pixel_row_t row;
        row.px.red          = CH_BITS'(r);
        row.px.green        = CH_BITS'(g);
        row.px.blue         = CH_BITS'(b);
        row.known           = known;
        row.want.hue        = HUE_BITS'(h);
        row.want.saturation = CH_BITS'(s);
        row.want.value      = CH_BITS'(v);
        pixel_plan.push_back(row);
    endtask

    task automatic send_pixel(rgb_t px, bit known, hsv_t want);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                pixel_valid <= 1'b0;
                @(posedge clk);
            end
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        hsv_pending.push_back(known ? want : hsv_of(px));
    endtask

    task automatic check_hsv(hsv_t got);
        hsv_t want;
        if (hsv_pending.size() == 0)
        begin
            $error("unexpected hsv transfer: hue %0d saturation %0d value %0d",
                   got.hue, got.saturation, got.value);
            errors++;
            return;
        end
        want = hsv_pending.pop_front();
        if (got.hue !== want.hue)
        begin
            $error("hue: expected %0d, actual %0d", want.hue, got.hue);
            errors++;
        end
        if (got.saturation !== want.saturation)
        begin
            $error("saturation: expected %0d, actual %0d", want.saturation, got.saturation);
            errors++;
        end
        if (got.value !== want.value)
        begin
            $error("value: expected %0d, actual %0d", want.value, got.value);
            errors++;
        end
    endtask

    // output side: check every transfer, then pick the next cycle's stall
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && hsv_valid && !hsv_stall)
                check_hsv(hsv);
            hsv_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin
        rgb_t px;
        hsv_t none;
        int   top;
        int   low;
        int   pick;
        none = '0;

        // gray and extreme colors, results known by inspection
        add_row(0,   0,   0,   1'b1, 0,     0,   0);
        add_row(255, 255, 255, 1'b1, 0,     0,   255);
        add_row(128, 128, 128, 1'b1, 0,     0,   128);
        add_row(1,   1,   1,   1'b1, 0,     0,   1);
        add_row(255, 0,   0,   1'b1, 0,     255, 255);
        add_row(0,   255, 0,   1'b1, 7680,  255, 255);
        add_row(0,   0,   255, 1'b1, 15360, 255, 255);
        add_row(255, 255, 0,   1'b1, 3840,  255, 255);
        add_row(0,   255, 255, 1'b1, 11520, 255, 255);
        add_row(255, 0,   255, 1'b1, 19200, 255, 255);
        add_row(1,   0,   0,   1'b1, 0,     255, 1);
        // negative hue wrap, ties, mid colors, alternating bit patterns
        add_row(255, 0,   1,   1'b0, 0, 0, 0);
        add_row(255, 1,   0,   1'b0, 0, 0, 0);
        add_row(255, 254, 254, 1'b0, 0, 0, 0);
        add_row(254, 255, 255, 1'b0, 0, 0, 0);
        add_row(255, 255, 254, 1'b0, 0, 0, 0);
        add_row(200, 100, 50,  1'b0, 0, 0, 0);
        add_row(50,  200, 100, 1'b0, 0, 0, 0);
        add_row(100, 50,  200, 1'b0, 0, 0, 0);
        add_row(170, 85,  255, 1'b0, 0, 0, 0);
        add_row(1,   2,   3,   1'b0, 0, 0, 0);
        add_row(8'hAA, 8'h55, 8'hAA, 1'b0, 0, 0, 0);
        add_row(8'h55, 8'hAA, 8'h55, 1'b0, 0, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (pixel_plan[i])
            send_pixel(pixel_plan[i].px, pixel_plan[i].known, pixel_plan[i].want);

        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            calm <= (i >= CALM_FIRST) && (i < CALM_LAST);
            if (i == DRAIN_AT)
            begin
                // hold the input until the pipeline has emptied
                pixel_valid <= 1'b0;
                do
                    @(posedge clk);
                while (hsv_pending.size() != 0);
            end
            top = $urandom_range(0, 255);
            low = $urandom_range(0, top);
            case ($urandom_range(0, 9))
                5:
                begin
                    px = '{CH_BITS'(top), CH_BITS'(top), CH_BITS'(top)};
                end
                6:
                begin
                    // two channels share the maximum
                    pick = $urandom_range(0, 2);
                    px.red   = CH_BITS'((pick == 2) ? low : top);
                    px.green = CH_BITS'((pick == 1) ? low : top);
                    px.blue  = CH_BITS'((pick == 0) ? low : top);
                end
                7:
                begin
                    px.red   = CH_BITS'($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
                                                             : $urandom_range(0, 1));
                    px.green = CH_BITS'($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
                                                             : $urandom_range(0, 1));
                    px.blue  = CH_BITS'($urandom_range(0, 255));
                end
                8:
                begin
                    // near gray, delta of at most two
                    top = $urandom_range(2, 255);
                    px.red   = CH_BITS'(top - $urandom_range(0, 2));
                    px.green = CH_BITS'(top - $urandom_range(0, 2));
                    px.blue  = CH_BITS'(top - $urandom_range(0, 2));
                end
                default:
                begin
                    px.red   = CH_BITS'($urandom_range(0, 255));
                    px.green = CH_BITS'($urandom_range(0, 255));
                    px.blue  = CH_BITS'($urandom_range(0, 255));
                end
            endcase
            send_pixel(px, 1'b0, none);
        end

        pixel_valid <= 1'b0;
        calm        <= 1'b0;
        do
            @(posedge clk);
        while (hsv_pending.size() != 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_rgb_to_hsv_converter_top: PASS");
        else
            $display("tb_rgb_to_hsv_converter_top: FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb_rgb_to_hsv_converter_top: FAIL");
        $finish;
    end

endmodule
